@@ sv/olst_pkg.sv @@
// Shared types and codes for the ordered list store.
package olst_pkg;

    // Operation selector codes
    localparam logic [2:0] OP_APPEND      = 3'd0;
    localparam logic [2:0] OP_INSERT      = 3'd1;
    localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
    localparam logic [2:0] OP_REMOVE_AT   = 3'd3;
    localparam logic [2:0] OP_READ        = 3'd4;
    localparam logic [2:0] OP_FIND        = 3'd5;
    localparam logic [2:0] OP_SWAP        = 3'd6;
    localparam logic [2:0] OP_CLEAR       = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Request payload
    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  position;
        logic [5:0]  other_position;
        logic [31:0] item_value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [5:0]  found_index;
        logic [6:0]  entry_count;
    } t_rsp;

endpackage

@@ sv/olst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ordered_list_store.sv @@
// Ordered list store: a fixed-capacity list of 32-bit handles kept in one RAM.
//
// Usage: present a request on i_req and raise start; it is taken at a clock
// edge where start is high and busy is low. Each request yields exactly one
// result on o_rsp, marked by o_strobe for a single cycle. The receiver cannot
// stall, so the result must be captured in that cycle.
// Append, remove last, clear and any rejected request finish without leaving
// idle; read passes through S_RD, and swap through S_SWA, S_SWB and S_SWC;
// insert moves one entry up per cycle, top first, down to the position;
// remove at moves the entries above the position down, one per cycle;
// find compares one entry per cycle and stops at the first match.
// The rate is set by the single RAM read port and the single write port:
// shifts stream one read and one write per cycle. Only one request is in
// flight at a time; busy stays high until its result is strobed.
// Reset clears the entry count and the control state; RAM contents are not
// cleared, since only entries below the count are ever read.
module ordered_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  olst_pkg::t_req     i_req,
    output logic               o_strobe,
    output olst_pkg::t_rsp     o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_DOWN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;
    localparam logic [2:0] S_SWA  = 3'd5;
    localparam logic [2:0] S_SWB  = 3'd6;
    localparam logic [2:0] S_SWC  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_pos2, n_pos2;
    logic [31:0]      r_val, n_val;
    logic [31:0]      r_hold, n_hold;
    logic             r_rv, n_rv;
    logic [IDX_W-1:0] r_ra, n_ra;
    logic             r_out_vld, n_out_vld;
    olst_pkg::t_rsp   r_out, n_out;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      mem_rdata;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] pos2_c;
    logic [CMP_W-1:0] cnt_c;
    logic             issue;

    // Entry storage
    olst_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Widen operands to a common compare width
    assign pos_c  = CMP_W'(i_req.position);
    assign pos2_c = CMP_W'(i_req.other_position);
    assign cnt_c  = CMP_W'(r_count);

    // Sequencer: decode requests, stream shifts and scans through the RAM
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pos2    = r_pos2;
        n_val     = r_val;
        n_hold    = r_hold;
        n_out_vld = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_ra;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_ra;
        issue     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val                = i_req.item_value;
                    n_out.status         = olst_pkg::ST_OK;
                    n_out.read_value     = '0;
                    n_out.found_index    = '0;
                    unique case (i_req.op)
                        olst_pkg::OP_APPEND: begin
                            n_out_vld = 1'b1;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_out.status = olst_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'(r_count);
                                mem_wdata = i_req.item_value;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        olst_pkg::OP_INSERT: begin
                            if (pos_c > cnt_c) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_RANGE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_FULL;
                            end else begin
                                n_pos   = CNT_W'(pos_c);
                                n_idx   = r_count;
                                n_state = S_UP;
                            end
                        end
                        olst_pkg::OP_REMOVE_LAST: begin
                            n_out_vld = 1'b1;
                            if (r_count == '0) begin
                                n_out.status = olst_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        olst_pkg::OP_REMOVE_AT: begin
                            if (r_count == '0) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_EMPTY;
                            end else if (pos_c >= cnt_c) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_RANGE;
                            end else begin
                                n_idx   = CNT_W'(pos_c) + CNT_W'(1);
                                n_state = S_DOWN;
                            end
                        end
                        olst_pkg::OP_READ: begin
                            if (pos_c >= cnt_c) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = IDX_W'(pos_c);
                                n_state   = S_RD;
                            end
                        end
                        olst_pkg::OP_FIND: begin
                            if (r_count == '0) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_NOT_FOUND;
                            end else begin
                                n_idx   = '0;
                                n_state = S_FIND;
                            end
                        end
                        olst_pkg::OP_SWAP: begin
                            if (pos_c >= cnt_c || pos2_c >= cnt_c) begin
                                n_out_vld    = 1'b1;
                                n_out.status = olst_pkg::ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = IDX_W'(pos_c);
                                n_pos     = CNT_W'(pos_c);
                                n_pos2    = IDX_W'(pos2_c);
                                n_state   = S_SWA;
                            end
                        end
                        olst_pkg::OP_CLEAR: begin
                            n_out_vld = 1'b1;
                            n_count   = '0;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end

            // Move entries up, top first; each write lands in the cycle after its read
            S_UP: begin
                issue = (r_idx > r_pos);
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx - CNT_W'(1));
                    n_idx     = r_idx - CNT_W'(1);
                end
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ra + IDX_W'(1);
                    mem_wdata = mem_rdata;
                end else if (!issue) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(r_pos);
                    mem_wdata = r_val;
                    n_count   = r_count + CNT_W'(1);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // Move entries down, bottom first; each write lands in the cycle after its read
            S_DOWN: begin
                issue = (r_idx < r_count);
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx);
                    n_idx     = r_idx + CNT_W'(1);
                end
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ra - IDX_W'(1);
                    mem_wdata = mem_rdata;
                end else if (!issue) begin
                    n_count   = r_count - CNT_W'(1);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // Return the read data
            S_RD: begin
                n_out.read_value = mem_rdata;
                n_out_vld        = 1'b1;
                n_state          = S_IDLE;
            end

            // Scan upward, compare one entry per cycle, stop at first match or last entry
            S_FIND: begin
                if (r_rv && mem_rdata == r_val) begin
                    n_out.found_index = 6'(r_ra);
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end else if (r_rv && r_ra == IDX_W'(r_count - CNT_W'(1))) begin
                    n_out.status = olst_pkg::ST_NOT_FOUND;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx);
                    n_idx     = r_idx + CNT_W'(1);
                end
            end

            // Hold the first entry, fetch the second
            S_SWA: begin
                n_hold    = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_pos2;
                n_state   = S_SWB;
            end

            // Write the second entry into the first slot
            S_SWB: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(r_pos);
                mem_wdata = mem_rdata;
                n_state   = S_SWC;
            end

            // Write the held entry into the second slot
            S_SWC: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos2;
                mem_wdata = r_hold;
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rv              = mem_re;
        n_ra              = mem_raddr;
        n_out.entry_count = 7'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rv      <= n_rv;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_pos2 <= n_pos2;
        r_val  <= n_val;
        r_hold <= n_hold;
        r_ra   <= n_ra;
        r_out  <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_rsp    = r_out;

    // Count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Leaving the busy phase always delivers a result
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // A result follows an accepted request or a busy phase
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy) || $past(busy))
        else $error("result strobe without a request");

    // The RAM is not written while idle without a request
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |-> !mem_we)
        else $error("RAM write while idle");

endmodule
